// ===== src/assert_macros.svh =====
// assertion macros shared by the rprop weight update rtl
// expects aclk and aresetn in the scope of every use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RWU_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rwu assertion failed");
`define RWU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rwu assertion failed");
`else
`define RWU_ASSERT_IMPLY(lbl, ante, cons)
`define RWU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== src/rwu_pkg.sv =====
// types, constants and codes for the rprop weight update unit
// no dependencies
`default_nettype none
package rwu_pkg;

    localparam int WEIGHT_COUNT = 4096;
    localparam int INDEX_W      = 12;
    localparam int ADDR_W       = $clog2(WEIGHT_COUNT);
    localparam int WORD_W       = 32;
    localparam int STEP_W       = 31;
    localparam int GROW_W       = 14;
    localparam int SHRINK_W     = 12;
    localparam int SIGN_W       = 2;
    localparam int PROD_W       = STEP_W + GROW_W;
    localparam int FRAC_SHIFT   = 12;
    localparam int ROUND_HALF   = 2048;
    localparam int CFG_INDEX_W  = 3;
    localparam int ENTRY_W      = WORD_W + STEP_W + SIGN_W;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    localparam logic [SIGN_W-1:0] SIGN_NONE = 2'd0;
    localparam logic [SIGN_W-1:0] SIGN_POS  = 2'd1;
    localparam logic [SIGN_W-1:0] SIGN_NEG  = 2'd2;

    localparam logic [1:0] MODE_KEEP   = 2'd0;
    localparam logic [1:0] MODE_GROW   = 2'd1;
    localparam logic [1:0] MODE_SHRINK = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_GROW   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHRINK = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_INIT   = 3'd4;

    localparam logic [GROW_W-1:0]   GROW_RESET   = 14'd4915;
    localparam logic [SHRINK_W-1:0] SHRINK_RESET = 12'd2048;
    localparam logic [STEP_W-1:0]   MAX_RESET    = 31'd838860800;
    localparam logic [STEP_W-1:0]   MIN_RESET    = 31'd17;
    localparam logic [STEP_W-1:0]   INIT_RESET   = 31'd1677722;

    typedef struct packed {
        logic                     op;
        logic [INDEX_W-1:0]       weight_index;
        logic signed [WORD_W-1:0] weight_value;
        logic signed [WORD_W-1:0] activation;
        logic signed [WORD_W-1:0] error_term;
    } rwu_in_t;

    typedef struct packed {
        logic [INDEX_W-1:0]       out_index;
        logic signed [WORD_W-1:0] new_weight;
        logic [STEP_W-1:0]        new_step;
        logic                     moved;
        logic                     saturated;
    } rwu_out_t;

    typedef struct packed {
        logic [GROW_W-1:0]   grow_factor;
        logic [SHRINK_W-1:0] shrink_factor;
        logic [STEP_W-1:0]   step_max;
        logic [STEP_W-1:0]   step_min;
        logic [STEP_W-1:0]   step_initial;
    } rwu_cfg_t;

    typedef struct packed {
        logic capture;
        logic decide;
        logic scale;
    } rwu_ctrl_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] weight;
        logic [STEP_W-1:0]        step;
        logic [SIGN_W-1:0]        sign;
    } rwu_entry_t;

endpackage
`default_nettype wire

// ===== src/rwu_ram.sv =====
// generic single-port-write ram with one registered read port
// no dependencies
`default_nettype none
module rwu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]              rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== src/rwu_calc.sv =====
// datapath: sign decision, step scaling and saturating weight update
// depends on rwu_pkg
`default_nettype none
module rwu_calc
    import rwu_pkg::*;
(
    input  wire logic       aclk,
    input  wire rwu_ctrl_t  ctrl,
    input  wire rwu_cfg_t   cfg,
    input  wire rwu_in_t    item,
    input  wire rwu_entry_t rd_entry,
    output rwu_out_t        result,
    output rwu_entry_t      wr_entry
);

    rwu_in_t                  item_reg;
    logic signed [WORD_W-1:0] weight_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [SIGN_W-1:0]        grad_reg;
    logic [SIGN_W-1:0]        sign_reg, sign_next;
    logic [1:0]               mode_reg, mode_next;
    logic                     apply_reg, apply_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic [STEP_W-1:0]        scaled_reg, scaled_next;

    logic [SIGN_W-1:0]  grad, prev;
    logic [GROW_W-1:0]  factor;
    logic [PROD_W:0]    rounded;
    logic [WORD_W-1:0]  scaled;
    logic [WORD_W:0]    sum;
    logic               sat;
    logic [WORD_W-1:0]  clamped;

    // decide: gradient sign against remembered sign
    always_comb begin
        grad = SIGN_NONE;
        if (item_reg.activation != '0 && item_reg.error_term != '0) begin
            grad = (item_reg.activation[WORD_W-1] == item_reg.error_term[WORD_W-1]) ?
                   SIGN_POS : SIGN_NEG;
        end
        prev = (rd_entry.sign == SIGN_POS || rd_entry.sign == SIGN_NEG) ?
               rd_entry.sign : SIGN_NONE;
        priority if (prev != SIGN_NONE && grad != SIGN_NONE && prev == grad) begin
            mode_next  = MODE_GROW;
            sign_next  = grad;
            apply_next = 1'b1;
        end else if (prev != SIGN_NONE && grad != SIGN_NONE) begin
            mode_next  = MODE_SHRINK;
            sign_next  = SIGN_NONE;
            apply_next = 1'b0;
        end else begin
            mode_next  = MODE_KEEP;
            sign_next  = grad;
            apply_next = (grad != SIGN_NONE);
        end
        factor    = (mode_next == MODE_GROW) ? cfg.grow_factor :
                    GROW_W'(cfg.shrink_factor);
        prod_next = PROD_W'(rd_entry.step) * PROD_W'(factor);
    end

    // scale: round, truncate and clamp the step
    always_comb begin
        rounded = {1'b0, prod_reg} + (PROD_W + 1)'(ROUND_HALF);
        scaled  = rounded[FRAC_SHIFT +: WORD_W];
        unique case (mode_reg)
            MODE_GROW: begin
                scaled_next = (scaled > {1'b0, cfg.step_max}) ? cfg.step_max :
                              scaled[STEP_W-1:0];
            end
            MODE_SHRINK: begin
                scaled_next = (scaled < {1'b0, cfg.step_min}) ? cfg.step_min :
                              scaled[STEP_W-1:0];
            end
            default: begin
                scaled_next = step_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            item_reg <= item;
        end
        if (ctrl.decide) begin
            weight_reg <= rd_entry.weight;
            step_reg   <= rd_entry.step;
            grad_reg   <= grad;
            sign_reg   <= sign_next;
            mode_reg   <= mode_next;
            apply_reg  <= apply_next;
            prod_reg   <= prod_next;
        end
        if (ctrl.scale) begin
            scaled_reg <= scaled_next;
        end
    end

    // weight sum with saturation
    always_comb begin
        if (grad_reg == SIGN_POS) begin
            sum = {weight_reg[WORD_W-1], weight_reg} + (WORD_W + 1)'(scaled_reg);
        end else begin
            sum = {weight_reg[WORD_W-1], weight_reg} - (WORD_W + 1)'(scaled_reg);
        end
        sat     = (sum[WORD_W] != sum[WORD_W-1]);
        clamped = sat ? {sum[WORD_W], {(WORD_W - 1){~sum[WORD_W]}}} : sum[WORD_W-1:0];

        result.out_index = item_reg.weight_index;
        if (item_reg.op == OP_LOAD) begin
            result.new_weight = item_reg.weight_value;
            result.new_step   = cfg.step_initial;
            result.moved      = 1'b0;
            result.saturated  = 1'b0;
            wr_entry.sign     = SIGN_NONE;
        end else begin
            result.new_weight = apply_reg ? clamped : weight_reg;
            result.new_step   = scaled_reg;
            result.moved      = apply_reg;
            result.saturated  = apply_reg && sat;
            wr_entry.sign     = sign_reg;
        end
        wr_entry.weight = result.new_weight;
        wr_entry.step   = result.new_step;
    end

endmodule
`default_nettype wire

// ===== src/rprop_weight_update_unit.sv =====
// top level: control sequencer, configuration registers, state ram, output register
// depends on rwu_pkg, rwu_ram, rwu_calc and assert_macros.svh
//
//  channel | ports                              | direction
//  s_      | s_valid s_ready s_data (rwu_in_t)  | item in
//  m_      | m_valid m_ready m_data (rwu_out_t) | result out
//  cfg_    | cfg_valid cfg_ready cfg_index cfg_data | register write
//
// an item passes four steps: transfer with ram read, decision with step multiply,
// step round and clamp, weight add with ram write-back into the output register.
// the next item is accepted the cycle after write-back, so items do not overlap.
// the ram has no reset; an entry is defined once a load item has written it.
// a held result keeps the item in write-back and s_ready low; cfg writes are always taken.
`default_nettype none
`include "assert_macros.svh"
module rprop_weight_update_unit
    import rwu_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire rwu_in_t                s_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output rwu_out_t                    m_data,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]      cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_MULT = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    rwu_out_t   m_data_reg;
    rwu_cfg_t   cfg_reg, cfg_next;

    rwu_ctrl_t  ctrl;
    rwu_out_t   result;
    rwu_entry_t wr_entry, rd_entry;
    logic [ENTRY_W-1:0] rd_word;
    logic       out_free, wr_en, s_xfer;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_xfer    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign wr_en     = (state_reg == ST_DONE) && out_free;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign rd_entry  = rd_word;

    assign ctrl.capture = s_xfer;
    assign ctrl.decide  = (state_reg == ST_READ);
    assign ctrl.scale   = (state_reg == ST_MULT);

    always_comb begin
        unique case (state_reg)
            ST_IDLE: state_next = s_xfer ? ST_READ : ST_IDLE;
            ST_READ: state_next = ST_MULT;
            ST_MULT: state_next = ST_DONE;
            default: state_next = out_free ? ST_IDLE : ST_DONE;
        endcase
        m_valid_next = wr_en ? 1'b1 : (m_valid_reg && !m_ready);
    end

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_GROW:   cfg_next.grow_factor   = cfg_data[GROW_W-1:0];
                CFG_SHRINK: cfg_next.shrink_factor = cfg_data[SHRINK_W-1:0];
                CFG_MAX:    cfg_next.step_max      = cfg_data[STEP_W-1:0];
                CFG_MIN:    cfg_next.step_min      = cfg_data[STEP_W-1:0];
                CFG_INIT:   cfg_next.step_initial  = cfg_data[STEP_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg                 <= ST_IDLE;
            m_valid_reg               <= 1'b0;
            cfg_reg.grow_factor       <= GROW_RESET;
            cfg_reg.shrink_factor     <= SHRINK_RESET;
            cfg_reg.step_max          <= MAX_RESET;
            cfg_reg.step_min          <= MIN_RESET;
            cfg_reg.step_initial      <= INIT_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            cfg_reg     <= cfg_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            m_data_reg <= result;
        end
    end

    rwu_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (WEIGHT_COUNT)
    ) u_state_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (result.out_index[ADDR_W-1:0]),
        .wr_data (wr_entry),
        .rd_en   (s_xfer),
        .rd_addr (s_data.weight_index[ADDR_W-1:0]),
        .rd_data (rd_word)
    );

    rwu_calc u_calc (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .cfg      (cfg_reg),
        .item     (s_data),
        .rd_entry (rd_entry),
        .result   (result),
        .wr_entry (wr_entry)
    );

    `RWU_ASSERT_NEXT(a_xfer_to_read, s_xfer, state_reg == ST_READ)
    `RWU_ASSERT_IMPLY(a_wr_only_done, wr_en, state_reg == ST_DONE)
    `RWU_ASSERT_NEXT(a_wr_sets_valid, wr_en, m_valid_reg && state_reg == ST_IDLE)
    `RWU_ASSERT_IMPLY(a_sat_needs_move, wr_en && result.saturated, result.moved)

endmodule
`default_nettype wire
